// ===== hw/rtl/swfp_pkg.sv =====
package swfp_pkg;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_SHORT     = 3'd1,
    STAT_BAD_HDR   = 3'd2,
    STAT_BAD_CSUM  = 3'd3,
    STAT_BAD_FUNC  = 3'd4,
    STAT_SHORT_PAY = 3'd5,
    STAT_RANGE     = 3'd6
  } status_t;

  // Configuration register indexes
  localparam logic REG_MIN_WEIGHT = 1'b0;
  localparam logic REG_MAX_WEIGHT = 1'b1;

  // Frame format
  localparam logic [7:0] HDR_BYTE       = 8'hdf;
  localparam logic [7:0] FUNC_WEIGHT    = 8'h03;
  localparam logic [7:0] CMD_WEIGHT     = 8'h00;
  localparam logic [8:0] MIN_LENGTH     = 9'd19;
  localparam logic [7:0] MIN_PAYLOAD    = 8'd13;
  localparam logic [8:0] PAYLOAD_OFFSET = 9'd6;

  // Byte positions within the frame
  localparam int POS_HDR0    = 0;
  localparam int POS_HDR1    = 1;
  localparam int POS_FUNC    = 2;
  localparam int POS_CMD     = 3;
  localparam int POS_LEN     = 4;
  localparam int POS_W_FIRST = 5;
  localparam int POS_W_LAST  = 8;

  localparam logic signed [31:0] MIN_WEIGHT_RST = -32'sd100000;
  localparam logic signed [31:0] MAX_WEIGHT_RST = 32'sd100000;

endpackage

// ===== hw/rtl/scale_weight_frame_parser_top.sv =====
// Scale weight notification frame parser.
//
// Input channel (in_valid/in_ready): one packet byte per transaction, with
// in_final_byte high on the last byte of a packet, which is the checksum.
// Non-final bytes update the byte count, the running modulo-256 sum, the
// header check, the function/command/length captures and the big-endian
// weight shifter, and produce no result.
// Output channel (out_valid/out_ready): one transaction per final byte,
// carrying a status code and the weight in tenths of a gram (zero unless the
// status is ok or out of range).
// The result is registered. Throughput: one byte per cycle while in_ready is
// high; every byte's work is one add, a few compares and a byte shift between
// the input and the result register.
// Stall: a result waiting on out_ready does not block input; a second result
// goes to a one-entry skid register, and only while that register is full is
// in_ready low.
// Reset (rst_n low, synchronous): packet state clears, both output registers
// empty, weight limits return to -100000 and 100000 tenths.
// Configuration: cfg_we writes cfg_wdata to register cfg_index (0 minimum,
// 1 maximum weight) in the same cycle; write only while the block is idle.
module scale_weight_frame_parser_top #(
  parameter int MAX_PACKET_BYTES = 63
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_packet_byte,
  input  logic               in_final_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status,
  output logic signed [31:0] out_weight_tenths,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_PACKET_BYTES + 1);

  // Configuration
  logic signed [31:0] min_weight_r;
  logic signed [31:0] max_weight_r;

  // Packet state
  logic [CNT_W-1:0] byte_count_r;
  logic [7:0]       running_sum_r;
  logic             header_good_r;
  logic [7:0]       function_code_r;
  logic [7:0]       command_code_r;
  logic [7:0]       payload_length_r;
  logic [31:0]      weight_shift_r;

  // Result register and skid register
  logic                   out_valid_r;
  swfp_pkg::status_t      out_status_r;
  logic signed [31:0]     out_weight_r;
  logic                   skid_valid_r;
  swfp_pkg::status_t      skid_status_r;
  logic signed [31:0]     skid_weight_r;

  logic                   in_take;
  logic                   out_take;
  logic                   res_valid;
  logic [CNT_W-1:0]       count_nxt;
  logic [8:0]             pkt_len;
  logic [8:0]             need_len;
  swfp_pkg::status_t      res_status;
  logic signed [31:0]     res_weight;
  logic signed [31:0]     cap_weight;

  assign in_ready  = !skid_valid_r;
  assign in_take   = in_valid && in_ready;
  assign out_take  = out_valid_r && out_ready;
  assign res_valid = in_take && in_final_byte;

  // Saturating byte count; the saturated value serves as the packet length.
  assign count_nxt = (byte_count_r < CNT_W'(MAX_PACKET_BYTES)) ?
                     byte_count_r + CNT_W'(1) : byte_count_r;
  assign pkt_len   = 9'(count_nxt);
  assign need_len  = swfp_pkg::PAYLOAD_OFFSET + {1'b0, payload_length_r};
  assign cap_weight = $signed(weight_shift_r);

  // Checks in priority order; the first failure sets the status.
  always_comb begin
    res_weight = '0;
    if (pkt_len < swfp_pkg::MIN_LENGTH) begin
      res_status = swfp_pkg::STAT_SHORT;
    end else if (!header_good_r) begin
      res_status = swfp_pkg::STAT_BAD_HDR;
    end else if (in_packet_byte != running_sum_r) begin
      res_status = swfp_pkg::STAT_BAD_CSUM;
    end else if (function_code_r != swfp_pkg::FUNC_WEIGHT ||
                 command_code_r != swfp_pkg::CMD_WEIGHT) begin
      res_status = swfp_pkg::STAT_BAD_FUNC;
    end else if (payload_length_r < swfp_pkg::MIN_PAYLOAD || pkt_len < need_len) begin
      res_status = swfp_pkg::STAT_SHORT_PAY;
    end else begin
      res_weight = cap_weight;
      if (cap_weight < min_weight_r || cap_weight > max_weight_r) begin
        res_status = swfp_pkg::STAT_RANGE;
      end else begin
        res_status = swfp_pkg::STAT_OK;
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_weight_r <= swfp_pkg::MIN_WEIGHT_RST;
      max_weight_r <= swfp_pkg::MAX_WEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        swfp_pkg::REG_MIN_WEIGHT: min_weight_r <= $signed(cfg_wdata);
        swfp_pkg::REG_MAX_WEIGHT: max_weight_r <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Packet state: advance on every accepted non-final byte, clear after the final one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r     <= '0;
      running_sum_r    <= '0;
      header_good_r    <= 1'b1;
      function_code_r  <= '0;
      command_code_r   <= '0;
      payload_length_r <= '0;
      weight_shift_r   <= '0;
    end else if (in_take) begin
      if (in_final_byte) begin
        byte_count_r     <= '0;
        running_sum_r    <= '0;
        header_good_r    <= 1'b1;
        function_code_r  <= '0;
        command_code_r   <= '0;
        payload_length_r <= '0;
        weight_shift_r   <= '0;
      end else begin
        byte_count_r  <= count_nxt;
        running_sum_r <= running_sum_r + in_packet_byte;
        if ((byte_count_r == CNT_W'(swfp_pkg::POS_HDR0) ||
             byte_count_r == CNT_W'(swfp_pkg::POS_HDR1)) &&
            in_packet_byte != swfp_pkg::HDR_BYTE) begin
          header_good_r <= 1'b0;
        end
        if (byte_count_r == CNT_W'(swfp_pkg::POS_FUNC)) begin
          function_code_r <= in_packet_byte;
        end
        if (byte_count_r == CNT_W'(swfp_pkg::POS_CMD)) begin
          command_code_r <= in_packet_byte;
        end
        if (byte_count_r == CNT_W'(swfp_pkg::POS_LEN)) begin
          payload_length_r <= in_packet_byte;
        end
        // Big-endian weight: shift in bytes 5 to 8
        if (byte_count_r >= CNT_W'(swfp_pkg::POS_W_FIRST) &&
            byte_count_r <= CNT_W'(swfp_pkg::POS_W_LAST)) begin
          weight_shift_r <= {weight_shift_r[23:0], in_packet_byte};
        end
      end
    end
  end

  // Output handshake: refill the result register from the skid entry first,
  // else load a new result when the register is free or draining; park a
  // new result in the skid entry when the receiver stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (!out_valid_r || out_take) begin
      out_valid_r <= res_valid;
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_status_r <= skid_status_r;
        out_weight_r <= skid_weight_r;
      end
    end else if (!out_valid_r || out_take) begin
      if (res_valid) begin
        out_status_r <= res_status;
        out_weight_r <= res_weight;
      end
    end else if (res_valid) begin
      skid_status_r <= res_status;
      skid_weight_r <= res_weight;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_weight_tenths = out_weight_r;

  // The skid entry is only ever filled behind a waiting result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry full with result register empty");

  // A final byte always leaves a result waiting on the next cycle.
  a_final_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_final_byte) |=> out_valid)
    else $error("final byte accepted without a result");

  // Packet state restarts after every final byte.
  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_final_byte) |=>
      (byte_count_r == '0 && running_sum_r == '0 && header_good_r))
    else $error("packet state not cleared after final byte");

  // Failed frames carry no weight.
  a_fail_zero_weight: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != 3'(swfp_pkg::STAT_OK) &&
     out_status != 3'(swfp_pkg::STAT_RANGE)) |-> (out_weight_tenths == '0))
    else $error("nonzero weight on a failed frame");

endmodule

// ===== tb/sv/tb_scale_weight_frame_parser_top.sv =====
module tb_scale_weight_frame_parser_top;

  localparam int CLK_PERIOD       = 8;
  localparam int RESET_CYCLES     = 11;
  localparam int FRAME_SAT        = 63;      // byte count saturates here
  localparam int SETTLE_LIMIT     = 5000;    // cycles to wait for stragglers
  localparam int TAIL_CYCLES      = 4;       // idle cycles after the last report
  localparam int RUN_LIMIT_CYCLES = 400000;
  localparam int PHASE_BYTES      = 270;     // four random phases

  // Ways a generated frame can be broken on purpose.
  typedef enum int {
    FLAW_NONE,
    FLAW_HDR,
    FLAW_CSUM,
    FLAW_FUNC,
    FLAW_CMD
  } flaw_t;

  // One weight report as the block should deliver it.
  typedef struct {
    swfp_pkg::status_t  status;
    logic signed [31:0] weight;
  } reading_t;

  logic               clk;
  logic               rst_n             = 1'b0;
  logic               in_valid          = 1'b0;
  logic               in_ready;
  logic [7:0]         in_packet_byte    = 8'h00;
  logic               in_final_byte     = 1'b0;
  logic               out_valid;
  logic               out_ready         = 1'b0;
  logic [2:0]         out_status;
  logic signed [31:0] out_weight_tenths;
  logic               cfg_we            = 1'b0;
  logic               cfg_index         = swfp_pkg::REG_MIN_WEIGHT;
  logic [31:0]        cfg_wdata         = '0;

  // Traffic shaping knobs, percent of cycles.
  int idle_pct    = 0;
  int stall_pct   = 0;
  // Long receiver hold-off, counted down by the receiver process.
  int hold_cycles = 0;

  int unsigned mismatch_count = 0;
  int unsigned bytes_sent     = 0;

  // Weight reports still owed by the block, oldest first.
  reading_t awaited_readings[$];

  // Shadow of the frame state and the weight limits.
  int unsigned        frm_count;
  logic [7:0]         frm_sum;
  bit                 frm_hdr_ok;
  logic [7:0]         frm_func;
  logic [7:0]         frm_cmd;
  logic [7:0]         frm_dlen;
  logic [31:0]        frm_weight;
  logic signed [31:0] lim_min;
  logic signed [31:0] lim_max;

  scale_weight_frame_parser_top #(
    .MAX_PACKET_BYTES(FRAME_SAT)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_packet_byte    (in_packet_byte),
    .in_final_byte     (in_final_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_weight_tenths (out_weight_tenths),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Hard stop in case the block hangs a channel.
  initial begin
    #(CLK_PERIOD * RUN_LIMIT_CYCLES);
    $display("Regression FAIL");
    $finish;
  end

  // ------------------------------------------------------------------
  // Frame shadow
  // ------------------------------------------------------------------

  function automatic void clear_frame();
    frm_count  = 0;
    frm_sum    = '0;
    frm_hdr_ok = 1'b1;
    frm_func   = '0;
    frm_cmd    = '0;
    frm_dlen   = '0;
    frm_weight = '0;
  endfunction

  // Fold one accepted byte into the frame shadow; on the final byte queue the
  // report the block owes and start a fresh frame.
  function automatic void track_frame_byte(input logic [7:0] b, input logic last);
    int unsigned        pos;
    reading_t           r;
    logic signed [31:0] w;
    pos = frm_count;
    if (frm_count < FRAME_SAT) frm_count++;
    if (!last) begin
      frm_sum += b;
      if (pos <= swfp_pkg::POS_HDR1 && b != swfp_pkg::HDR_BYTE) frm_hdr_ok = 1'b0;
      if (pos == swfp_pkg::POS_FUNC) frm_func = b;
      else if (pos == swfp_pkg::POS_CMD) frm_cmd = b;
      else if (pos == swfp_pkg::POS_LEN) frm_dlen = b;
      else if (pos >= swfp_pkg::POS_W_FIRST && pos <= swfp_pkg::POS_W_LAST)
        frm_weight = {frm_weight[23:0], b};
      return;
    end
    // Checks run in fixed priority; the weight only survives ok or range.
    r.weight = '0;
    if (frm_count < swfp_pkg::MIN_LENGTH) r.status = swfp_pkg::STAT_SHORT;
    else if (!frm_hdr_ok) r.status = swfp_pkg::STAT_BAD_HDR;
    else if (b != frm_sum) r.status = swfp_pkg::STAT_BAD_CSUM;
    else if (frm_func != swfp_pkg::FUNC_WEIGHT || frm_cmd != swfp_pkg::CMD_WEIGHT)
      r.status = swfp_pkg::STAT_BAD_FUNC;
    else if (frm_dlen < swfp_pkg::MIN_PAYLOAD ||
             frm_count < swfp_pkg::PAYLOAD_OFFSET + frm_dlen)
      r.status = swfp_pkg::STAT_SHORT_PAY;
    else begin
      w        = frm_weight;
      r.weight = w;
      r.status = (w < lim_min || w > lim_max) ? swfp_pkg::STAT_RANGE : swfp_pkg::STAT_OK;
    end
    awaited_readings.push_back(r);
    clear_frame();
  endfunction

  // ------------------------------------------------------------------
  // Checking
  // ------------------------------------------------------------------

  task automatic note_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Sample at the falling edge: whatever holds here is what the next rising
  // edge accepts.
  always @(negedge clk) begin
    reading_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_readings.size() == 0) begin
        note_mismatch($sformatf("unexpected result status %0d weight %0d",
                                out_status, out_weight_tenths));
      end else begin
        want = awaited_readings.pop_front();
        if (out_status !== want.status)
          note_mismatch($sformatf("status %0d, want %0d", out_status, want.status));
        if (out_weight_tenths !== want.weight)
          note_mismatch($sformatf("weight %0d, want %0d (status %0d)",
                                  out_weight_tenths, want.weight, want.status));
      end
    end
  end

  // Receiver: hold off for the requested stretch, otherwise stall at random.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_ready   <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------

  // Offer one byte and hold it until the block takes it. Valid is never
  // dropped here once raised; idle gaps lower it before the next offer.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_packet_byte <= b;
    in_final_byte  <= last;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    track_frame_byte(b, last);
    bytes_sent++;
  endtask

  function automatic logic [7:0] other_than(input logic [7:0] v);
    return v ^ 8'($urandom_range(1, 255));
  endfunction

  // Build a frame of len bytes (checksum included) and send it.
  task automatic send_frame(input int unsigned len, input logic [7:0] dlen,
                            input logic [31:0] weight, input flaw_t flaw);
    logic [7:0]  sum;
    logic [7:0]  b;
    int unsigned bad_pos;
    sum     = '0;
    bad_pos = $urandom_range(swfp_pkg::POS_HDR0, swfp_pkg::POS_HDR1);
    for (int unsigned i = 0; i + 1 < len; i++) begin
      if (i <= swfp_pkg::POS_HDR1)
        b = (flaw == FLAW_HDR && i == bad_pos) ? other_than(swfp_pkg::HDR_BYTE)
                                                : swfp_pkg::HDR_BYTE;
      else if (i == swfp_pkg::POS_FUNC)
        b = (flaw == FLAW_FUNC) ? other_than(swfp_pkg::FUNC_WEIGHT) : swfp_pkg::FUNC_WEIGHT;
      else if (i == swfp_pkg::POS_CMD)
        b = (flaw == FLAW_CMD) ? other_than(swfp_pkg::CMD_WEIGHT) : swfp_pkg::CMD_WEIGHT;
      else if (i == swfp_pkg::POS_LEN)
        b = dlen;
      else if (i <= swfp_pkg::POS_W_LAST)
        b = weight[8 * (swfp_pkg::POS_W_LAST - i) +: 8];
      else
        b = 8'($urandom);
      sum += b;
      send_byte(b, 1'b0);
    end
    send_byte((flaw == FLAW_CSUM) ? other_than(sum) : sum, 1'b1);
  endtask

  // Drop valid, wait for every owed report, then let the pipe go quiet.
  task automatic settle();
    int waited = 0;
    in_valid <= 1'b0;
    while (awaited_readings.size() != 0 && waited < SETTLE_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (awaited_readings.size() != 0) begin
      note_mismatch($sformatf("%0d results never arrived", awaited_readings.size()));
      awaited_readings.delete();
    end
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic idx, input logic signed [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == swfp_pkg::REG_MIN_WEIGHT) lim_min = val;
    else lim_max = val;
    @(posedge clk);
  endtask

  task automatic set_limits(input logic signed [31:0] lo, input logic signed [31:0] hi);
    settle();
    write_limit(swfp_pkg::REG_MIN_WEIGHT, lo);
    write_limit(swfp_pkg::REG_MAX_WEIGHT, hi);
  endtask

  // Weights clustered on and just past the current limits, plus wide ones.
  function automatic logic [31:0] pick_weight();
    int s;
    case ($urandom_range(5))
      0: return lim_min;
      1: return lim_max;
      2: return lim_min - 1;
      3: return lim_max + 1;
      4: return $urandom;
      default: begin
        s = $urandom_range(400000);
        return s - 200000;
      end
    endcase
  endfunction

  // Random bytes, closed by a final byte so the next frame starts clean.
  task automatic send_noise();
    int unsigned n;
    n = $urandom_range(1, 24);
    for (int unsigned i = 0; i < n; i++)
      send_byte(8'($urandom), (i + 1 == n) || ($urandom_range(9) == 0));
  endtask

  // Mostly well-formed frames with random content, the rest broken,
  // truncated or pure noise.
  task automatic run_random_phase(input int unsigned n_bytes);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned len;
    int unsigned cap;
    logic [7:0]  dlen;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        len  = ($urandom_range(9) == 0) ? $urandom_range(29, 80) : $urandom_range(19, 28);
        cap  = (len > FRAME_SAT) ? FRAME_SAT : len;
        dlen = ($urandom_range(6) == 0) ?
               8'($urandom) :
               8'($urandom_range(swfp_pkg::MIN_PAYLOAD, cap - swfp_pkg::PAYLOAD_OFFSET));
        send_frame(len, dlen, pick_weight(), FLAW_NONE);
      end else if (pick < 80) begin
        len = $urandom_range(19, 28);
        send_frame(len,
                   8'($urandom_range(swfp_pkg::MIN_PAYLOAD, len - swfp_pkg::PAYLOAD_OFFSET)),
                   pick_weight(), flaw_t'($urandom_range(FLAW_HDR, FLAW_CMD)));
      end else if (pick < 90) begin
        send_frame($urandom_range(1, swfp_pkg::MIN_LENGTH - 1), swfp_pkg::MIN_PAYLOAD,
                   pick_weight(), FLAW_NONE);
      end else begin
        send_noise();
      end
    end
  endtask

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // Every status code but short, under the reset limits, with a nonzero weight
  // carried in each failing frame so that the zeroed weight is checked too.
  task automatic test_status_codes();
    idle_pct  = 0;
    stall_pct = 0;
    send_frame(19, 13, 32'sd100000, FLAW_NONE);
    send_frame(20, 14, -32'sd100000, FLAW_NONE);
    send_frame(19, 13, 32'sd100001, FLAW_NONE);
    send_frame(19, 13, -32'sd100001, FLAW_NONE);
    send_frame(19, 13, 32'sd777, FLAW_HDR);
    send_frame(19, 13, 32'sd4242, FLAW_CSUM);
    send_frame(19, 13, 32'sd55, FLAW_FUNC);
    send_frame(19, 13, 32'sd56, FLAW_CMD);
    send_frame(19, 12, 32'sd99, FLAW_NONE);
    send_frame(24, 19, 32'sd98, FLAW_NONE);
    send_frame(25, 19, 32'sd97, FLAW_NONE);
    settle();
  endtask

  // Length edges: lone final byte, one byte short, and frames at and past the
  // byte-count saturation point.
  task automatic test_frame_edges();
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    send_frame(18, 13, 32'sd10, FLAW_NONE);
    send_frame(63, 57, 32'sd11, FLAW_NONE);
    send_frame(70, 57, 32'sd12, FLAW_NONE);
    send_frame(70, 58, 32'sd13, FLAW_NONE);
    send_frame(80, 8'hff, 32'sd14, FLAW_NONE);
    settle();
  endtask

  // Limit registers at their extremes, a single-value window and empty windows.
  task automatic test_weight_limits();
    set_limits(32'sh8000_0000, 32'sh7fff_ffff);
    send_frame(19, 13, 32'h8000_0000, FLAW_NONE);
    send_frame(19, 13, 32'h7fff_ffff, FLAW_NONE);
    send_frame(19, 13, 32'h0000_0000, FLAW_NONE);
    set_limits(32'sd1234, 32'sd1234);
    send_frame(19, 13, 32'sd1234, FLAW_NONE);
    send_frame(19, 13, 32'sd1233, FLAW_NONE);
    send_frame(19, 13, 32'sd1235, FLAW_NONE);
    set_limits(32'sd1, 32'sd0);
    send_frame(19, 13, 32'sd0, FLAW_NONE);
    send_frame(19, 13, 32'sd1, FLAW_NONE);
    set_limits(32'sh7fff_ffff, 32'sh8000_0000);
    send_frame(19, 13, 32'sh7fff_ffff, FLAW_NONE);
    send_frame(19, 13, 32'sh8000_0000, FLAW_NONE);
    settle();
  endtask

  // Hold the receiver off while a burst of one-byte frames piles up results,
  // so the output and skid registers fill and input stalls.
  task automatic test_backpressure();
    set_limits(-32'sd100000, 32'sd100000);
    idle_pct    = 0;
    stall_pct   = 0;
    hold_cycles = 120;
    send_frame(19, 13, 32'sd500, FLAW_NONE);
    repeat (16) send_byte(8'($urandom), 1'b1);
    send_frame(22, 16, 32'sd501, FLAW_NONE);
    settle();
  endtask

  // Random traffic under four limit settings and four idling mixes.
  task automatic test_random_traffic();
    logic signed [31:0] a;
    logic signed [31:0] b;
    set_limits(-32'sd100000, 32'sd100000);
    idle_pct  = 0;
    stall_pct = 0;
    run_random_phase(PHASE_BYTES);

    a = $urandom_range(32'h4000_0000);
    set_limits(a, a - 32'($urandom_range(1, 100000)));
    idle_pct  = 80;
    stall_pct = 0;
    run_random_phase(PHASE_BYTES);

    set_limits(32'sh8000_0000, 32'sh7fff_ffff);
    idle_pct  = 0;
    stall_pct = 80;
    run_random_phase(PHASE_BYTES);

    a = $urandom;
    b = $urandom;
    if (a > b) set_limits(b, a);
    else set_limits(a, b);
    idle_pct  = 18;
    stall_pct = 18;
    run_random_phase(PHASE_BYTES);
    settle();
  endtask

  initial begin
    clear_frame();
    lim_min = swfp_pkg::MIN_WEIGHT_RST;
    lim_max = swfp_pkg::MAX_WEIGHT_RST;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_status_codes();
    test_frame_edges();
    test_weight_limits();
    test_backpressure();
    test_random_traffic();

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/swfp_pkg.sv
hw/rtl/scale_weight_frame_parser_top.sv
tb/sv/tb_scale_weight_frame_parser_top.sv
